FILE: src/mfsde_pkg.sv
package mfsde_pkg;

    // Signed pixel coordinate, wide enough for a circle point before clipping.
    typedef logic signed [10:0] t_crd;

    localparam int unsigned STW = 4;

    // Controller state codes.
    localparam logic [STW-1:0] S_CLR  = 4'd0;
    localparam logic [STW-1:0] S_IDLE = 4'd1;
    localparam logic [STW-1:0] S_PRD  = 4'd2;
    localparam logic [STW-1:0] S_PWR  = 4'd3;
    localparam logic [STW-1:0] S_NEXT = 4'd4;
    localparam logic [STW-1:0] S_RD   = 4'd5;
    localparam logic [STW-1:0] S_RDW  = 4'd6;
    localparam logic [STW-1:0] S_CRR  = 4'd7;
    localparam logic [STW-1:0] S_CSQ  = 4'd8;
    localparam logic [STW-1:0] S_CCMP = 4'd9;
    localparam logic [STW-1:0] S_CPT  = 4'd10;
    localparam logic [STW-1:0] S_CSQA = 4'd11;
    localparam logic [STW-1:0] S_CUPD = 4'd12;
    localparam logic [STW-1:0] S_DONE = 4'd13;

    // Command kinds.
    localparam logic [2:0] K_PIXEL  = 3'd0;
    localparam logic [2:0] K_RECT   = 3'd1;
    localparam logic [2:0] K_LINE   = 3'd2;
    localparam logic [2:0] K_CIRCLE = 3'd3;
    localparam logic [2:0] K_READ   = 3'd4;

endpackage

FILE: src/mono_frame_store_draw_engine_top.sv
// Monochrome frame store with a small drawing engine.
// The store holds COLUMNS x (PAGES*8) pixels as page bytes, one byte per column
// and page, in a single synchronous memory with a registered read.
// A request on the input channel (i_in_valid / o_in_ready) carries a command:
// set or clear one pixel, fill or clear a rectangle, draw a line, draw a circle
// outline, or read one page byte. Each request yields exactly one response on
// the output channel (o_out_valid / i_out_ready), carrying the page byte for a
// read and zero for every other command.
// The engine works on one request at a time. Every plotted pixel is a
// read-modify-write of the memory through the read, write and step states.
// A pixel command plots one pixel and a read fetches one page byte. Lines
// plot one pixel per iteration, rectangles every covered pixel, and circles
// the eight symmetric points of each step of the walk, followed by squaring
// and comparing to choose the next step.
// Clipped pixels still pass through these states but do not write the memory.
// After reset the memory is cleared one byte per cycle, all COLUMNS*PAGES bytes,
// while o_in_ready stays low. The finished response sits in an output register,
// so a new request is taken while it waits; a stalled receiver only stops the
// engine when a second response is ready and the first has not been taken.
module mono_frame_store_draw_engine_top #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_x_start,
    input  logic [7:0] i_y_start,
    input  logic [7:0] i_x_end,
    input  logic [7:0] i_y_end,
    input  logic [7:0] i_radius,
    input  logic       i_ink,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int ROWS  = PAGES * 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

    logic [7:0] mem [DEPTH];

    logic [mfsde_pkg::STW-1:0] r_state;
    logic [AW-1:0]             r_clr;
    logic [2:0]                r_kind;
    logic                      r_ink;
    mfsde_pkg::t_crd           r_px, r_py;
    logic [8:0]                r_x0, r_y0, r_x1, r_y1;
    logic [7:0]                r_dx, r_dy, r_dist;
    logic [8:0]                r_ex, r_ey, r_cnt;
    logic                      r_sx, r_sy;
    logic [8:0]                r_a;
    logic [7:0]                r_b, r_r;
    logic [15:0]               r_rr, r_bb;
    logic [17:0]               r_aa;
    logic [2:0]                r_idx;
    logic                      r_czero;
    logic                      r_hit;
    logic [AW-1:0]             r_addr;
    logic [7:0]                r_mask, r_rd, r_res;
    logic                      r_ov;
    logic [7:0]                r_odata;

    logic          p_in, rd_in, mem_re, mem_we;
    logic [AW-1:0] p_addr, rd_addr, mem_ra, mem_wa;
    logic [7:0]    mem_wd;
    logic [8:0]    x1c, y1c, exn, eyn;
    logic [7:0]    adx, ady;
    mfsde_pkg::t_crd cxs, cys, as, bs, cpx, cpy;
    logic          accept;

    assign accept     = i_in_valid && (r_state == mfsde_pkg::S_IDLE);
    assign o_in_ready = (r_state == mfsde_pkg::S_IDLE);

    // Current point against the screen, and its byte address.
    assign p_in = !r_px[10] && !r_py[10] && (r_px < 11'(COLUMNS)) && (r_py < 11'(ROWS));
    assign p_addr = AW'(r_px[XW-1:0]) * AW'(PAGES) + AW'(r_py[PW+2:3]);

    assign rd_in   = ({1'b0, r_x0} < 10'(COLUMNS)) && ({1'b0, r_y0} < 10'(PAGES));
    assign rd_addr = AW'(r_x0[XW-1:0]) * AW'(PAGES) + AW'(r_y0[PW-1:0]);

    // Rectangle end clipped to the screen.
    assign x1c = ({1'b0, i_x_end} > 9'(COLUMNS - 1)) ? 9'(COLUMNS - 1) : {1'b0, i_x_end};
    assign y1c = ({1'b0, i_y_end} > 9'(ROWS - 1)) ? 9'(ROWS - 1) : {1'b0, i_y_end};

    assign adx = (i_x_end >= i_x_start) ? i_x_end - i_x_start : i_x_start - i_x_end;
    assign ady = (i_y_end >= i_y_start) ? i_y_end - i_y_start : i_y_start - i_y_end;

    assign exn = r_ex + {1'b0, r_dx};
    assign eyn = r_ey + {1'b0, r_dy};

    // Eight symmetric circle points.
    assign cxs = $signed({2'b00, r_x0});
    assign cys = $signed({2'b00, r_y0});
    assign as  = $signed({2'b00, r_a});
    assign bs  = $signed({3'b000, r_b});

    always_comb begin
        cpx = cxs;
        cpy = cys;
        case (r_idx)
            3'd0: begin cpx = cxs + as; cpy = cys - bs; end
            3'd1: begin cpx = cxs - as; cpy = cys - bs; end
            3'd2: begin cpx = cxs - as; cpy = cys + bs; end
            3'd3: begin cpx = cxs + as; cpy = cys + bs; end
            3'd4: begin cpx = cxs + bs; cpy = cys + as; end
            3'd5: begin cpx = cxs + bs; cpy = cys - as; end
            3'd6: begin cpx = cxs - bs; cpy = cys - as; end
            default: begin cpx = cxs - bs; cpy = cys + as; end
        endcase
    end

    // Memory port control.
    assign mem_re = (r_state == mfsde_pkg::S_PRD) || (r_state == mfsde_pkg::S_RD);
    assign mem_ra = (r_state == mfsde_pkg::S_RD) ? rd_addr : p_addr;
    assign mem_we = (r_state == mfsde_pkg::S_CLR) || ((r_state == mfsde_pkg::S_PWR) && r_hit);
    assign mem_wa = (r_state == mfsde_pkg::S_CLR) ? r_clr : r_addr;
    assign mem_wd = (r_state == mfsde_pkg::S_CLR) ? 8'd0 :
                    (r_ink ? (r_rd | r_mask) : (r_rd & ~r_mask));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    // Command sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfsde_pkg::S_CLR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                mfsde_pkg::S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= mfsde_pkg::S_IDLE;
                    end
                end
                mfsde_pkg::S_IDLE: begin
                    if (accept) begin
                        r_kind  <= i_kind;
                        // The circle always sets its pixels, whatever the ink.
                        r_ink   <= i_ink || (i_kind == mfsde_pkg::K_CIRCLE);
                        r_res   <= 8'd0;
                        r_x0    <= {1'b0, i_x_start};
                        r_y0    <= {1'b0, i_y_start};
                        r_x1    <= x1c;
                        r_y1    <= y1c;
                        r_px    <= $signed({3'b000, i_x_start});
                        r_py    <= $signed({3'b000, i_y_start});
                        r_dx    <= adx;
                        r_dy    <= ady;
                        r_dist  <= (adx > ady) ? adx : ady;
                        r_sx    <= (i_x_end < i_x_start);
                        r_sy    <= (i_y_end < i_y_start);
                        r_ex    <= '0;
                        r_ey    <= '0;
                        r_cnt   <= '0;
                        r_a     <= '0;
                        r_b     <= i_radius;
                        r_r     <= i_radius;
                        r_czero <= (i_radius == 8'd0);
                        r_idx   <= '0;
                        case (i_kind)
                            mfsde_pkg::K_PIXEL, mfsde_pkg::K_LINE: begin
                                r_state <= mfsde_pkg::S_PRD;
                            end
                            mfsde_pkg::K_RECT: begin
                                if (({1'b0, i_x_start} <= x1c) && ({1'b0, i_y_start} <= y1c)) begin
                                    r_state <= mfsde_pkg::S_PRD;
                                end else begin
                                    r_state <= mfsde_pkg::S_DONE;
                                end
                            end
                            mfsde_pkg::K_CIRCLE: begin
                                if (i_radius == 8'd0) begin
                                    r_state <= mfsde_pkg::S_PRD;
                                end else begin
                                    r_state <= mfsde_pkg::S_CRR;
                                end
                            end
                            mfsde_pkg::K_READ: r_state <= mfsde_pkg::S_RD;
                            default: r_state <= mfsde_pkg::S_DONE;
                        endcase
                    end
                end
                mfsde_pkg::S_PRD: begin
                    r_hit   <= p_in;
                    r_addr  <= p_addr;
                    r_mask  <= 8'd1 << r_py[2:0];
                    r_state <= mfsde_pkg::S_PWR;
                end
                mfsde_pkg::S_PWR: begin
                    r_state <= mfsde_pkg::S_NEXT;
                end
                mfsde_pkg::S_NEXT: begin
                    case (r_kind)
                        mfsde_pkg::K_RECT: begin
                            if (r_py < $signed({2'b00, r_y1})) begin
                                r_py    <= r_py + 11'sd1;
                                r_state <= mfsde_pkg::S_PRD;
                            end else if (r_px < $signed({2'b00, r_x1})) begin
                                r_px    <= r_px + 11'sd1;
                                r_py    <= $signed({2'b00, r_y0});
                                r_state <= mfsde_pkg::S_PRD;
                            end else begin
                                r_state <= mfsde_pkg::S_DONE;
                            end
                        end
                        mfsde_pkg::K_LINE: begin
                            if (r_cnt == {1'b0, r_dist} + 9'd1) begin
                                r_state <= mfsde_pkg::S_DONE;
                            end else begin
                                r_cnt <= r_cnt + 9'd1;
                                if (exn > {1'b0, r_dist}) begin
                                    r_ex <= exn - {1'b0, r_dist};
                                    r_px <= r_sx ? r_px - 11'sd1 : r_px + 11'sd1;
                                end else begin
                                    r_ex <= exn;
                                end
                                if (eyn > {1'b0, r_dist}) begin
                                    r_ey <= eyn - {1'b0, r_dist};
                                    r_py <= r_sy ? r_py - 11'sd1 : r_py + 11'sd1;
                                end else begin
                                    r_ey <= eyn;
                                end
                                r_state <= mfsde_pkg::S_PRD;
                            end
                        end
                        mfsde_pkg::K_CIRCLE: begin
                            if (r_czero) begin
                                r_state <= mfsde_pkg::S_DONE;
                            end else if (r_idx != 3'd7) begin
                                r_idx   <= r_idx + 3'd1;
                                r_state <= mfsde_pkg::S_CPT;
                            end else begin
                                r_state <= mfsde_pkg::S_CSQA;
                            end
                        end
                        default: r_state <= mfsde_pkg::S_DONE;
                    endcase
                end
                mfsde_pkg::S_RD: begin
                    r_hit   <= rd_in;
                    r_state <= mfsde_pkg::S_RDW;
                end
                mfsde_pkg::S_RDW: begin
                    r_res   <= r_hit ? r_rd : 8'd0;
                    r_state <= mfsde_pkg::S_DONE;
                end
                mfsde_pkg::S_CRR: begin
                    r_rr    <= 16'(r_r) * 16'(r_r);
                    r_state <= mfsde_pkg::S_CSQ;
                end
                mfsde_pkg::S_CSQ: begin
                    r_bb    <= 16'(r_b) * 16'(r_b);
                    r_state <= mfsde_pkg::S_CCMP;
                end
                mfsde_pkg::S_CCMP: begin
                    if ({r_bb, 1'b0} >= {1'b0, r_rr}) begin
                        r_idx   <= '0;
                        r_state <= mfsde_pkg::S_CPT;
                    end else begin
                        r_state <= mfsde_pkg::S_DONE;
                    end
                end
                mfsde_pkg::S_CPT: begin
                    r_px    <= cpx;
                    r_py    <= cpy;
                    r_state <= mfsde_pkg::S_PRD;
                end
                mfsde_pkg::S_CSQA: begin
                    r_aa    <= 18'(r_a + 9'd1) * 18'(r_a + 9'd1);
                    r_state <= mfsde_pkg::S_CUPD;
                end
                mfsde_pkg::S_CUPD: begin
                    // Stepping a past the circle is undone by stepping b inward instead.
                    if (r_aa + {2'b00, r_bb} > {2'b00, r_rr}) begin
                        r_b <= r_b - 8'd1;
                    end else begin
                        r_a <= r_a + 9'd1;
                    end
                    r_state <= mfsde_pkg::S_CSQ;
                end
                mfsde_pkg::S_DONE: begin
                    if (!r_ov || i_out_ready) begin
                        r_state <= mfsde_pkg::S_IDLE;
                    end
                end
                default: r_state <= mfsde_pkg::S_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == mfsde_pkg::S_DONE) && (!r_ov || i_out_ready)) begin
            r_ov    <= 1'b1;
            r_odata <= r_res;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_read_data = r_odata;

endmodule
